// ----- hw/rtl/prv_pkg.sv -----
// Shared types, status codes and CRC helper for the preset record validator.
`default_nettype none

package prv_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SLOT = 3'd1;
    localparam logic [2:0] ST_IO       = 3'd2;
    localparam logic [2:0] ST_MAGIC    = 3'd3;
    localparam logic [2:0] ST_VERSION  = 3'd4;
    localparam logic [2:0] ST_SIZE     = 3'd5;
    localparam logic [2:0] ST_CRC      = 3'd6;

    // Item kinds
    localparam logic REQ_HEADER  = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_VERSION      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SIZE    = 2'd2;

    // Command opcodes from front to back
    localparam logic [2:0] OP_RESTART = 3'd0;  // header ok: reset CRC, load expected CRC
    localparam logic [2:0] OP_REPORT  = 3'd1;  // header verdict: reset CRC, emit status
    localparam logic [2:0] OP_BYTE    = 3'd2;  // fold one payload byte
    localparam logic [2:0] OP_LAST    = 3'd3;  // fold final byte, emit verdict
    localparam logic [2:0] OP_ABORT   = 3'd4;  // payload read error

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_RESET_EXPECTED = 16'h0000;
    localparam logic [31:0] RECORD_MAGIC = {8'h44, 8'h58, 8'h50, 8'h31};

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  status;
        logic [15:0] arg;    // expected CRC or payload byte
    } cmd_t;

    // CRC-16/CCITT-FALSE update, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/prv_if.sv -----
// Channel interfaces: input item channel and result channel.
`default_nettype none

interface prv_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  slot;
    logic [31:0] magic_word;
    logic [7:0]  stored_version;
    logic [7:0]  stored_slot;
    logic [15:0] stored_size;
    logic [15:0] stored_crc;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        read_error;

    modport source (
        output valid, req_type, slot, magic_word, stored_version, stored_slot,
               stored_size, stored_crc, data_byte, last_byte, read_error,
        input  ready
    );
    modport sink (
        input  valid, req_type, slot, magic_word, stored_version, stored_slot,
               stored_size, stored_crc, data_byte, last_byte, read_error,
        output ready
    );
endinterface

interface prv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] computed_crc;

    modport source (output valid, status, computed_crc, input ready);
    modport sink   (input valid, status, computed_crc, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/prv_front.sv -----
// Front end: config registers, header checks, record tracking, command issue.
`default_nettype none

module prv_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [prv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [prv_pkg::CFG_DATA_W-1:0] cfg_data,
    prv_in_if.sink                              item,
    output logic                                push_valid,
    output prv_pkg::cmd_t                       push_cmd,
    input  wire logic                           push_ready
);
    import prv_pkg::*;

    logic [7:0]  hdr_version_reg;
    logic [7:0]  slot_count_reg;
    logic [15:0] expected_size_reg;
    logic        record_open_reg;
    logic        record_open_next;
    logic        want_push;
    logic        accept;

    assign item.ready = push_ready;
    assign accept     = item.valid & push_ready;
    assign push_valid = accept & want_push;

    always_comb
    begin
        want_push        = 1'b0;
        record_open_next = record_open_reg;
        push_cmd.op      = OP_REPORT;
        push_cmd.status  = ST_OK;
        push_cmd.arg     = item.stored_crc;
        if (item.req_type == REQ_HEADER)
        begin
            want_push        = 1'b1;
            record_open_next = 1'b0;
            if (item.slot >= slot_count_reg)
                push_cmd.status = ST_BAD_SLOT;
            else if (item.read_error)
                push_cmd.status = ST_IO;
            else if (item.magic_word != RECORD_MAGIC)
                push_cmd.status = ST_MAGIC;
            else if (item.stored_version != hdr_version_reg)
                push_cmd.status = ST_VERSION;
            else if (item.stored_slot != item.slot || item.stored_size != expected_size_reg)
                push_cmd.status = ST_SIZE;
            else if (expected_size_reg == 16'd0)
                // empty payload: verdict comes straight from the stored CRC
                push_cmd.status = (item.stored_crc == CRC_INIT) ? ST_OK : ST_CRC;
            else
            begin
                push_cmd.op      = OP_RESTART;
                record_open_next = 1'b1;
            end
        end
        else if (record_open_reg)
        begin
            want_push    = 1'b1;
            push_cmd.arg = {8'h00, item.data_byte};
            if (item.read_error)
            begin
                push_cmd.op      = OP_ABORT;
                push_cmd.status  = ST_IO;
                record_open_next = 1'b0;
            end
            else if (item.last_byte)
            begin
                push_cmd.op      = OP_LAST;
                record_open_next = 1'b0;
            end
            else
                push_cmd.op = OP_BYTE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_version_reg    <= 8'd1;
            slot_count_reg     <= 8'd8;
            expected_size_reg  <= 16'd256;
            record_open_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HDR_VERSION:    hdr_version_reg    <= cfg_data[7:0];
                    CFG_SLOT_COUNT:     slot_count_reg     <= cfg_data[7:0];
                    CFG_EXPECTED_SIZE:  expected_size_reg  <= cfg_data;
                    default:            ;
                endcase
            end
            if (accept)
                record_open_reg <= record_open_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/prv_queue.sv -----
// Short command queue between front and back.
`default_nettype none

module prv_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    input  prv_pkg::cmd_t push_cmd,
    output logic         push_ready,
    output logic         pop_valid,
    output prv_pkg::cmd_t pop_cmd,
    input  wire logic    pop_ready
);
    import prv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/prv_back.sv -----
// Back end: running CRC, verdicts and the output register.
`default_nettype none

module prv_back (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     pop_valid,
    input  prv_pkg::cmd_t pop_cmd,
    output logic          pop_ready,
    prv_out_if.source     result
);
    import prv_pkg::*;

    logic [15:0] running_crc_reg;
    logic [15:0] expected_crc_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [2:0]  status_reg;
    logic [15:0] crc_out_reg;
    logic [15:0] folded_crc;
    logic        take;
    logic        emit;

    assign pop_ready           = ~out_valid_reg | result.ready;
    assign take                = pop_valid & pop_ready;
    assign emit                = take & (pop_cmd.op == OP_REPORT || pop_cmd.op == OP_LAST ||
                                         pop_cmd.op == OP_ABORT);
    assign out_valid_next      = emit | (out_valid_reg & ~result.ready);
    assign folded_crc          = crc_byte(running_crc_reg, pop_cmd.arg[7:0]);
    assign result.valid        = out_valid_reg;
    assign result.status       = status_reg;
    assign result.computed_crc = crc_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg  <= CRC_INIT;
            expected_crc_reg <= CRC_RESET_EXPECTED;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                unique case (pop_cmd.op)
                    OP_RESTART:
                    begin
                        running_crc_reg  <= CRC_INIT;
                        expected_crc_reg <= pop_cmd.arg;
                    end
                    OP_REPORT:
                        running_crc_reg <= CRC_INIT;
                    OP_BYTE:
                        running_crc_reg <= folded_crc;
                    OP_LAST:
                        running_crc_reg <= folded_crc;
                    OP_ABORT: ;
                    default: ;
                endcase
            end
        end
    end

    // result payload, loaded only when a verdict is issued
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            case (pop_cmd.op)
                OP_REPORT:
                begin
                    status_reg  <= pop_cmd.status;
                    crc_out_reg <= CRC_INIT;
                end
                OP_LAST:
                begin
                    status_reg  <= (folded_crc == expected_crc_reg) ? ST_OK : ST_CRC;
                    crc_out_reg <= folded_crc;
                end
                OP_ABORT:
                begin
                    status_reg  <= ST_IO;
                    crc_out_reg <= running_crc_reg;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/preset_record_validator.sv -----
// Top level of the preset record validator.
//
//   port      dir  protocol            carries
//   cfg_*     in   write enable        header version, slot count, payload size
//   item      in   valid/ready         header or payload byte item
//   result    out  valid/ready         status, computed_crc
//
// One item per cycle sustained while the queue has room; the front pushes into
// the queue on the transfer edge, then the back pops it, folds the byte with a
// CRC-16 update and loads the output register, which drives result valid.
// Reset clears config to defaults, the queue, the open-record flag and the CRC.
// Input ready drops only when the command queue is full; the queue absorbs
// stalls on the result side.
`default_nettype none

module preset_record_validator #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [prv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [prv_pkg::CFG_DATA_W-1:0] cfg_data,
    prv_in_if.sink                              item,
    prv_out_if.source                           result
);
    import prv_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    prv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item       (item),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    prv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    prv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule

`default_nettype wire
